// File: rtl/core/x86enc_pkg.sv
`default_nettype none

package x86enc_pkg;

    localparam int MAX_BYTES = 10;
    localparam int CNT_W     = 4;

    typedef enum logic [4:0] {
        KIND_MOV8_IMM    = 5'd0,
        KIND_MOV32_IMM   = 5'd1,
        KIND_MOV32_REG   = 5'd2,
        KIND_MOV32_STORE = 5'd3,
        KIND_MOV64_IMM   = 5'd4,
        KIND_MOV64_REG   = 5'd5,
        KIND_MOV64_STORE = 5'd6,
        KIND_ALU32_REG   = 5'd7,
        KIND_ALU32_IMM   = 5'd8,
        KIND_ALU64_REG   = 5'd9,
        KIND_ALU64_IMM   = 5'd10,
        KIND_PUSH_REG    = 5'd11,
        KIND_PUSH_IMM8   = 5'd12,
        KIND_PUSH_IMM32  = 5'd13,
        KIND_POP_REG     = 5'd14,
        KIND_JMP_REL8    = 5'd15,
        KIND_JCC_REL8    = 5'd16,
        KIND_JMP_REL32   = 5'd17,
        KIND_JCC_REL32   = 5'd18,
        KIND_SYSCALL     = 5'd19
    } kind_t;

    localparam logic [7:0] PFX_REXW       = 8'h48;
    localparam logic [7:0] OPC_MOV_RM     = 8'h89;
    localparam logic [7:0] OPC_GRP1_IMM32 = 8'h81;
    localparam logic [7:0] OPC_MOV_IMM32  = 8'hB8;
    localparam logic [7:0] OPC_MOV_IMM8   = 8'hB0;
    localparam logic [7:0] OPC_ESCAPE     = 8'h0F;
    localparam logic [7:0] OPC_JMP32      = 8'hE9;
    localparam logic [7:0] OPC_JMP8       = 8'hEB;
    localparam logic [7:0] OPC_PUSH_IMM8  = 8'h6A;
    localparam logic [7:0] OPC_PUSH_IMM32 = 8'h68;
    localparam logic [7:0] MODRM_REGREG   = 8'hC0;
    localparam logic [7:0] OPC_PUSH_REG   = 8'h50;
    localparam logic [7:0] OPC_POP_REG    = 8'h58;
    localparam logic [7:0] OPC_JCC8       = 8'h70;
    localparam logic [7:0] OPC_JCC32      = 8'h80;
    localparam logic [7:0] OPC_SYSCALL    = 8'h05;
    localparam logic [2:0] RM_RIP         = 3'b101;
    localparam logic [2:0] ALU_RM_LOW     = 3'b001;
    localparam logic [2:0] ALU_ACC_LOW    = 3'b101;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } enc_t;

    function automatic enc_t encode(
        input kind_t       kind,
        input logic [2:0]  ra,
        input logic [2:0]  rb,
        input logic [2:0]  op,
        input logic [3:0]  cc,
        input logic [63:0] imm
    );
        enc_t                  e;
        logic [5:0][7:0]       alu_body;
        logic [CNT_W-1:0]      alu_len;
        logic [7:0]            regreg;
        logic [7:0]            ripst;
        logic [7:0]            alu_rm;
        e        = '0;
        alu_body = '0;
        regreg   = MODRM_REGREG | {2'b00, ra, rb};
        ripst    = {2'b00, ra, RM_RIP};
        alu_rm   = {2'b00, op, ALU_RM_LOW};
        if (ra == 3'd0)
        begin
            alu_body[0]   = {2'b00, op, ALU_ACC_LOW};
            alu_body[4:1] = imm[31:0];
            alu_len       = CNT_W'(5);
        end
        else
        begin
            alu_body[0]   = OPC_GRP1_IMM32;
            alu_body[1]   = MODRM_REGREG | {2'b00, op, ra};
            alu_body[5:2] = imm[31:0];
            alu_len       = CNT_W'(6);
        end
        unique case (kind)
            KIND_MOV8_IMM:
            begin
                e.bytes[0] = OPC_MOV_IMM8 + {5'b0, ra};
                e.bytes[1] = imm[7:0];
                e.count    = CNT_W'(2);
            end
            KIND_MOV32_IMM:
            begin
                e.bytes[0]   = OPC_MOV_IMM32 + {5'b0, ra};
                e.bytes[4:1] = imm[31:0];
                e.count      = CNT_W'(5);
            end
            KIND_MOV32_REG:
            begin
                e.bytes[0] = OPC_MOV_RM;
                e.bytes[1] = regreg;
                e.count    = CNT_W'(2);
            end
            KIND_MOV32_STORE:
            begin
                e.bytes[0]   = OPC_MOV_RM;
                e.bytes[1]   = ripst;
                e.bytes[5:2] = imm[31:0];
                e.count      = CNT_W'(6);
            end
            KIND_MOV64_IMM:
            begin
                e.bytes[0]   = PFX_REXW;
                e.bytes[1]   = OPC_MOV_IMM32 + {5'b0, ra};
                e.bytes[9:2] = imm;
                e.count      = CNT_W'(10);
            end
            KIND_MOV64_REG:
            begin
                e.bytes[0] = PFX_REXW;
                e.bytes[1] = OPC_MOV_RM;
                e.bytes[2] = regreg;
                e.count    = CNT_W'(3);
            end
            KIND_MOV64_STORE:
            begin
                e.bytes[0]   = PFX_REXW;
                e.bytes[1]   = OPC_MOV_RM;
                e.bytes[2]   = ripst;
                e.bytes[6:3] = imm[31:0];
                e.count      = CNT_W'(7);
            end
            KIND_ALU32_REG:
            begin
                e.bytes[0] = alu_rm;
                e.bytes[1] = regreg;
                e.count    = CNT_W'(2);
            end
            KIND_ALU32_IMM:
            begin
                e.bytes[5:0] = alu_body;
                e.count      = alu_len;
            end
            KIND_ALU64_REG:
            begin
                e.bytes[0] = PFX_REXW;
                e.bytes[1] = alu_rm;
                e.bytes[2] = regreg;
                e.count    = CNT_W'(3);
            end
            KIND_ALU64_IMM:
            begin
                e.bytes[0]   = PFX_REXW;
                e.bytes[6:1] = alu_body;
                e.count      = alu_len + CNT_W'(1);
            end
            KIND_PUSH_REG:
            begin
                e.bytes[0] = OPC_PUSH_REG + {5'b0, ra};
                e.count    = CNT_W'(1);
            end
            KIND_PUSH_IMM8:
            begin
                e.bytes[0] = OPC_PUSH_IMM8;
                e.bytes[1] = imm[7:0];
                e.count    = CNT_W'(2);
            end
            KIND_PUSH_IMM32:
            begin
                e.bytes[0]   = OPC_PUSH_IMM32;
                e.bytes[4:1] = imm[31:0];
                e.count      = CNT_W'(5);
            end
            KIND_POP_REG:
            begin
                e.bytes[0] = OPC_POP_REG + {5'b0, ra};
                e.count    = CNT_W'(1);
            end
            KIND_JMP_REL8:
            begin
                e.bytes[0] = OPC_JMP8;
                e.bytes[1] = imm[7:0];
                e.count    = CNT_W'(2);
            end
            KIND_JCC_REL8:
            begin
                e.bytes[0] = OPC_JCC8 + {4'b0, cc};
                e.bytes[1] = imm[7:0];
                e.count    = CNT_W'(2);
            end
            KIND_JMP_REL32:
            begin
                e.bytes[0]   = OPC_JMP32;
                e.bytes[4:1] = imm[31:0];
                e.count      = CNT_W'(5);
            end
            KIND_JCC_REL32:
            begin
                e.bytes[0]   = OPC_ESCAPE;
                e.bytes[1]   = OPC_JCC32 + {4'b0, cc};
                e.bytes[5:2] = imm[31:0];
                e.count      = CNT_W'(6);
            end
            KIND_SYSCALL:
            begin
                e.bytes[0] = OPC_ESCAPE;
                e.bytes[1] = OPC_SYSCALL;
                e.count    = CNT_W'(2);
            end
            default:
            begin
                e.count = '0;
            end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/x86_64_instruction_encoder_unit.sv
`default_nettype none

// Encodes one x86-64 instruction request per input item into its machine code, sent out
// one byte per output item with tlast on the final byte. An instruction of N bytes
// (1 to 10) leaves as N byte items on the single byte lane, stalling on m_axis_tready;
// the next request is taken in the cycle its predecessor's last byte leaves, so
// instructions stream with no gap. Unknown kinds (20 to 31) are accepted and emit nothing.
module x86_64_instruction_encoder_unit
    import x86enc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // reg_a[2:0], reg_b[5:3], alu_op[8:6], cond_code[12:9], immediate[76:13], zero pad
    input  wire logic [79:0] s_axis_tdata,
    // kind[4:0]
    input  wire logic [4:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // code_byte[7:0]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);

    enc_t                      enc;
    logic                      in_fire;
    logic                      out_fire;
    logic                      done;

    logic [MAX_BYTES-1:0][7:0] buf_reg;
    logic [CNT_W-1:0]          idx_reg,  idx_next;
    logic [CNT_W-1:0]          last_reg, last_next;
    logic                      busy_reg, busy_next;

    assign enc = encode(kind_t'(s_axis_tuser[4:0]),
                        s_axis_tdata[2:0],
                        s_axis_tdata[5:3],
                        s_axis_tdata[8:6],
                        s_axis_tdata[12:9],
                        s_axis_tdata[76:13]);

    assign out_fire      = busy_reg && m_axis_tready;
    assign done          = out_fire && (idx_reg == last_reg);
    assign s_axis_tready = !busy_reg || done;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = buf_reg[idx_reg];
    assign m_axis_tlast  = (idx_reg == last_reg);

    always_comb
    begin
        idx_next  = idx_reg;
        last_next = last_reg;
        busy_next = busy_reg;
        if (in_fire)
        begin
            idx_next  = '0;
            last_next = enc.count - CNT_W'(1);
            busy_next = (enc.count != '0);
        end
        else if (out_fire)
        begin
            // advance to the next byte, or drop busy after the last one
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            last_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            last_reg <= last_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg <= enc.bytes;
        end
    end

endmodule

`default_nettype wire
